// ===== rtl/qat_pkg.sv =====
// ============================================================================
// Quadrature angle tracker package
// Shared widths, reset values, register indexes and decode helpers.
// ============================================================================
package qat_pkg;

    // Width of the internal angle counter.
    localparam int ANGLE_BITS = 11;

    // Width of every configuration register.
    localparam int CFG_BITS = 11;

    // Width of the output angle field and of the signed error field.
    localparam int ANGLE_OUT_BITS = 11;
    localparam int ERROR_OUT_BITS = 12;

    // The full difference is one bit wider than the wider operand.
    localparam int ERR_BITS = ((ANGLE_BITS > CFG_BITS) ? ANGLE_BITS : CFG_BITS) + 1;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_FIELD_BITS = ANGLE_OUT_BITS + ERROR_OUT_BITS + 2 + 3;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Reset values.
    localparam logic [CFG_BITS-1:0] REF_ANGLE_RST   = CFG_BITS'(300);
    localparam logic [CFG_BITS-1:0] ANGLE_TOP_RST   = CFG_BITS'(1199);
    localparam logic [CFG_BITS-1:0] WIDE_BAND_RST   = CFG_BITS'(50);
    localparam logic [CFG_BITS-1:0] NARROW_BAND_RST = CFG_BITS'(10);
    localparam logic [ANGLE_BITS-1:0] ANGLE_RST     = ANGLE_BITS'(900);

    // The accumulator takes a step once its magnitude passes this limit.
    localparam logic signed [3:0] ACC_LIMIT = 4'sd3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_REF_ANGLE   = 2'd0,
        CFG_ANGLE_TOP   = 2'd1,
        CFG_WIDE_BAND   = 2'd2,
        CFG_NARROW_BAND = 2'd3
    } t_cfg_reg;

    // Rotation classes reported on the output.
    typedef enum logic [1:0] {
        ROT_CW        = 2'd0,
        ROT_CCW       = 2'd1,
        ROT_CW_CCW    = 2'd2,
        ROT_CCW_CW    = 2'd3
    } t_rot_class;

    // Signed step for a move from the previous phase to the current one.
    // Gray-code neighbors give one step; no change or a double jump gives none.
    function automatic logic signed [3:0] phase_delta(input logic [1:0] prev,
                                                      input logic [1:0] cur);
        logic signed [3:0] d;
        case ({prev, cur}) inside
            4'b0001, 4'b0111, 4'b1110, 4'b1000: d = 4'sd1;
            4'b0010, 4'b1011, 4'b1101, 4'b0100: d = -4'sd1;
            default:                            d = 4'sd0;
        endcase
        return d;
    endfunction

    // Two-step direction history (bit 1 previous, bit 0 latest; 1 = ccw)
    // mapped onto its rotation class.
    function automatic t_rot_class rot_class(input logic [1:0] hist);
        t_rot_class c;
        case (hist)
            2'b00:   c = ROT_CW;
            2'b11:   c = ROT_CCW;
            2'b01:   c = ROT_CW_CCW;
            default: c = ROT_CCW_CW;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/quadrature_angle_tracker_core.sv =====
// ============================================================================
// Quadrature angle tracker core
// Decodes one sample of a two-channel incremental encoder into a wrapping
// angle count, its error against a reference and tolerance indicators.
// ============================================================================
//
// Usage:
//   Each input request on the s_axis channel carries one sample of encoder
//   channels A and B. Every accepted sample produces exactly one result on
//   the m_axis channel: the angle, the signed error reference minus angle,
//   the rotation class from the last two steps, the wide and narrow band
//   indicators and a flag that marks a sample that moved the angle.
//   The configuration channel writes the reference angle, the wrap top and
//   the two bands by index; it is always ready and is used while idle.
//
// Timing:
//   The result sits behind two register stages. The first stage decodes
//   the phase step and updates the accumulator and angle counter; the
//   second forms the error and the band compares. One sample is accepted
//   every cycle, limited only by the result receiver.
//
// Reset and stall:
//   A synchronous active-low reset restores the register defaults, puts the
//   angle at 900, clears the phase, accumulator and history and drops both
//   pipeline stages. When the receiver stalls, the result holds, the first
//   stage still fills, and s_axis_tready falls once both stages are full.
// ----------------------------------------------------------------------------
module quadrature_angle_tracker_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Sample stream. tdata: [0] channel_a, [1] channel_b, [7:2] zero.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [qat_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,

    // Result stream. tdata: [10:0] angle, [22:11] angle_error,
    // [24:23] rotation_class, [25] within_wide, [26] within_narrow,
    // [27] stepped, [31:28] zero.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [qat_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,

    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [qat_pkg::CFG_BITS-1:0]        i_cfg_data
);

    localparam int AB = qat_pkg::ANGLE_BITS;
    localparam int EB = qat_pkg::ERR_BITS;

    // Configuration registers.
    logic [qat_pkg::CFG_BITS-1:0] r_ref_angle;
    logic [AB-1:0]                r_angle_top;
    logic [qat_pkg::CFG_BITS-1:0] r_wide_band;
    logic [qat_pkg::CFG_BITS-1:0] r_narrow_band;

    // Decoder state.
    logic [1:0]        r_phase;
    logic signed [3:0] r_acc;
    logic [AB-1:0]     r_angle;
    logic [1:0]        r_hist;

    // First stage result.
    logic                r_s1_valid;
    logic [AB-1:0]       r_s1_angle;
    qat_pkg::t_rot_class r_s1_class;
    logic                r_s1_stepped;

    // Output register.
    logic                                 r_out_valid;
    logic [qat_pkg::OUT_DATA_BITS-1:0]    r_out_data;

    // Next values of the decoder state.
    logic [1:0]        n_phase;
    logic signed [3:0] n_acc;
    logic [AB-1:0]     n_angle;
    logic [1:0]        n_hist;
    logic              n_stepped;
    logic signed [3:0] w_sum;

    // Second stage arithmetic.
    logic signed [EB-1:0] w_err;
    logic [EB-1:0]        w_mag;
    logic                 w_wide;
    logic                 w_narrow;

    logic w_out_adv;
    logic w_accept;
    logic w_cfg_wr;

    // The output register frees up when empty or when its result is taken;
    // the first stage can take a sample when it is empty or can pass its own on.
    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || w_out_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Phase decode, accumulation and the angle count update.
    always_comb begin
        n_phase   = {s_axis_tdata[0], s_axis_tdata[1]};
        w_sum     = r_acc + qat_pkg::phase_delta(r_phase, n_phase);
        n_acc     = w_sum;
        n_angle   = r_angle;
        n_hist    = r_hist;
        n_stepped = 1'b0;
        if (w_sum > qat_pkg::ACC_LIMIT) begin
            n_hist    = {r_hist[0], 1'b1};
            n_angle   = (r_angle < r_angle_top) ? r_angle + AB'(1) : '0;
            n_acc     = 4'sd0;
            n_stepped = 1'b1;
        end else if (w_sum < -qat_pkg::ACC_LIMIT) begin
            n_hist    = {r_hist[0], 1'b0};
            n_angle   = (r_angle != '0) ? r_angle - AB'(1) : r_angle_top;
            n_acc     = 4'sd0;
            n_stepped = 1'b1;
        end
    end

    // Error against the reference and the two band compares.
    always_comb begin
        w_err    = $signed(EB'(r_ref_angle)) - $signed(EB'(r_s1_angle));
        w_mag    = w_err[EB-1] ? EB'(-w_err) : EB'(w_err);
        w_wide   = (w_mag <= EB'(r_wide_band));
        w_narrow = (w_mag <  EB'(r_narrow_band));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_angle   <= qat_pkg::REF_ANGLE_RST;
            r_angle_top   <= AB'(qat_pkg::ANGLE_TOP_RST);
            r_wide_band   <= qat_pkg::WIDE_BAND_RST;
            r_narrow_band <= qat_pkg::NARROW_BAND_RST;
            r_phase       <= 2'b00;
            r_acc         <= 4'sd0;
            r_angle       <= qat_pkg::ANGLE_RST;
            r_hist        <= 2'b00;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (qat_pkg::t_cfg_reg'(i_cfg_index))
                    qat_pkg::CFG_REF_ANGLE:   r_ref_angle   <= i_cfg_data;
                    qat_pkg::CFG_ANGLE_TOP:   r_angle_top   <= AB'(i_cfg_data);
                    qat_pkg::CFG_WIDE_BAND:   r_wide_band   <= i_cfg_data;
                    qat_pkg::CFG_NARROW_BAND: r_narrow_band <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_angle <= n_angle;
                r_hist  <= n_hist;
            end

            if (s_axis_tready) begin
                r_s1_valid <= w_accept;
            end

            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_angle   <= n_angle;
            r_s1_class   <= qat_pkg::rot_class(n_hist);
            r_s1_stepped <= n_stepped;
        end
        if (w_out_adv && r_s1_valid) begin
            r_out_data <= {
                (qat_pkg::OUT_DATA_BITS - qat_pkg::OUT_FIELD_BITS)'(0),
                r_s1_stepped,
                w_narrow,
                w_wide,
                r_s1_class,
                qat_pkg::ERROR_OUT_BITS'(w_err),
                qat_pkg::ANGLE_OUT_BITS'(r_s1_angle)
            };
        end
    end

    // The accumulator never rests beyond the step limit.
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc <= qat_pkg::ACC_LIMIT) && (r_acc >= -qat_pkg::ACC_LIMIT))
        else $error("step accumulator left its range");

    // An empty output register always leaves room for a new sample.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // Every accepted sample lands in the first stage.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted sample was lost");

    // A stalled result keeps the first stage occupied, so nothing is dropped.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_s1_valid) |=> r_s1_valid)
        else $error("first stage dropped a result under stall");

endmodule

// ===== tb/sv/tb_quadrature_angle_tracker_core.sv =====
// ============================================================================
// Quadrature angle tracker core testbench
// Streams encoder samples through the core and checks every result
// against an in-bench predictor of the angle counter and its indicators.
// Register settings change between runs, and both stream sides idle at random.
// ============================================================================
module tb_quadrature_angle_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    localparam int CFG_BITS       = qat_pkg::CFG_BITS;
    localparam int ANGLE_BITS     = qat_pkg::ANGLE_BITS;
    localparam int IN_DATA_BITS   = qat_pkg::IN_DATA_BITS;
    localparam int OUT_DATA_BITS  = qat_pkg::OUT_DATA_BITS;
    localparam int ANGLE_OUT_BITS = qat_pkg::ANGLE_OUT_BITS;
    localparam int ERROR_OUT_BITS = qat_pkg::ERROR_OUT_BITS;

    // Register and state values right after reset.
    localparam logic [CFG_BITS-1:0]   RST_REF_ANGLE   = 11'd300;
    localparam logic [CFG_BITS-1:0]   RST_ANGLE_TOP   = 11'd1199;
    localparam logic [CFG_BITS-1:0]   RST_WIDE_BAND   = 11'd50;
    localparam logic [CFG_BITS-1:0]   RST_NARROW_BAND = 11'd10;
    localparam logic [ANGLE_BITS-1:0] RST_ANGLE       = 11'd900;

    // The accumulator must pass this magnitude before the angle moves.
    localparam int STEP_THRESHOLD = 3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index = qat_pkg::CFG_REF_ANGLE;
    logic [CFG_BITS-1:0]       i_cfg_data = '0;

    // Random idling on both stream sides is switched off for one run.
    bit gaps_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    quadrature_angle_tracker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Phases are written as {A, B}. Counter-clockwise order walks
    // 00 -> 01 -> 11 -> 10 -> 00; clockwise runs the other way.
    function automatic logic [1:0] ccw_next(input logic [1:0] p);
        case (p)
            2'b00:   return 2'b01;
            2'b01:   return 2'b11;
            2'b11:   return 2'b10;
            default: return 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] cw_next(input logic [1:0] p);
        case (p)
            2'b00:   return 2'b10;
            2'b10:   return 2'b11;
            2'b11:   return 2'b01;
            default: return 2'b00;
        endcase
    endfunction

    typedef struct {
        logic [ANGLE_OUT_BITS-1:0] angle;
        logic [ERROR_OUT_BITS-1:0] angle_error;
        qat_pkg::t_rot_class       rotation;
        logic                      within_wide;
        logic                      within_narrow;
        logic                      stepped;
    } t_angle_result;

    // Tracks the angle the core should report and holds the results that
    // are still owed, oldest first.
    class angle_checker;
        logic [CFG_BITS-1:0]   ref_angle;
        logic [CFG_BITS-1:0]   angle_top;
        logic [CFG_BITS-1:0]   wide_band;
        logic [CFG_BITS-1:0]   narrow_band;
        logic [1:0]            last_phase;
        int                    step_sum;
        logic [ANGLE_BITS-1:0] count;
        logic [1:0]            history;
        t_angle_result         expected_angles[$];
        int                    mismatches;
        int                    samples;
        int                    steps;
        int                    wraps;

        function new();
            ref_angle   = RST_REF_ANGLE;
            angle_top   = RST_ANGLE_TOP;
            wide_band   = RST_WIDE_BAND;
            narrow_band = RST_NARROW_BAND;
            last_phase  = 2'b00;
            step_sum    = 0;
            count       = RST_ANGLE;
            history     = 2'b00;
            mismatches  = 0;
            samples     = 0;
            steps       = 0;
            wraps       = 0;
        endfunction

        function void write_register(qat_pkg::t_cfg_reg idx, logic [CFG_BITS-1:0] value);
            case (idx)
                qat_pkg::CFG_REF_ANGLE:   ref_angle = value;
                qat_pkg::CFG_ANGLE_TOP:   angle_top = value;
                qat_pkg::CFG_WIDE_BAND:   wide_band = value;
                qat_pkg::CFG_NARROW_BAND: narrow_band = value;
                default: ;
            endcase
        endfunction

        function void predict_sample(logic chan_a, logic chan_b);
            logic [1:0]    phase;
            int            diff;
            int            mag;
            t_angle_result r;

            phase = {chan_a, chan_b};
            // A move to the next phase in the counter-clockwise order adds one,
            // a move back subtracts one; holding or jumping both channels adds 0.
            if (phase == ccw_next(last_phase))
                step_sum += 1;
            else if (last_phase == ccw_next(phase))
                step_sum -= 1;
            last_phase = phase;

            r.stepped = 1'b0;
            if (step_sum > STEP_THRESHOLD) begin
                history = {history[0], 1'b1};
                if (count < angle_top) begin
                    count = count + ANGLE_BITS'(1);
                end else begin
                    // This also covers a count left above a lowered top.
                    count = '0;
                    wraps++;
                end
                step_sum  = 0;
                r.stepped = 1'b1;
            end else if (step_sum < -STEP_THRESHOLD) begin
                history = {history[0], 1'b0};
                if (count != '0) begin
                    count = count - ANGLE_BITS'(1);
                end else begin
                    count = ANGLE_BITS'(angle_top);
                    wraps++;
                end
                step_sum  = 0;
                r.stepped = 1'b1;
            end
            if (r.stepped)
                steps++;

            diff = int'(ref_angle) - int'(count);
            mag  = (diff < 0) ? -diff : diff;

            r.angle         = ANGLE_OUT_BITS'(count);
            r.angle_error   = ERROR_OUT_BITS'(diff);
            if (history[1] == history[0])
                r.rotation = history[0] ? qat_pkg::ROT_CCW : qat_pkg::ROT_CW;
            else
                r.rotation = history[0] ? qat_pkg::ROT_CW_CCW : qat_pkg::ROT_CCW_CW;
            r.within_wide   = (mag <= int'(wide_band));
            r.within_narrow = (mag < int'(narrow_band));
            expected_angles.push_back(r);
            samples++;
        endfunction

        function void compare_field(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
            end
        endfunction

        function void check_angle_result(logic [OUT_DATA_BITS-1:0] tdata);
            t_angle_result want;

            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result 0x%08h arrived with no sample pending",
                             $realtime, tdata);
                return;
            end
            want = expected_angles.pop_front();
            // Error values are compared as raw 12-bit two's complement.
            compare_field("angle", 12'(want.angle), 12'(tdata[10:0]));
            compare_field("angle_error", want.angle_error, tdata[22:11]);
            compare_field("rotation_class", 12'(want.rotation), 12'(tdata[24:23]));
            compare_field("within_wide", 12'(want.within_wide), 12'(tdata[25]));
            compare_field("within_narrow", 12'(want.within_narrow), 12'(tdata[26]));
            compare_field("stepped", 12'(want.stepped), 12'(tdata[27]));
        endfunction
    endclass

    angle_checker angle_sb;
    int           settings_used = 0;

    // Opening walk from reset: a hold, two full counter-clockwise cycles,
    // a clockwise cycle, double jumps that must not count, another
    // clockwise cycle, single moves that stay short of a step, and double jumps.
    logic [1:0] opening_walk[24] = '{
        2'b00, 2'b01, 2'b11, 2'b10, 2'b00, 2'b01, 2'b11, 2'b10,
        2'b00, 2'b10, 2'b11, 2'b01, 2'b00, 2'b11, 2'b00, 2'b10,
        2'b11, 2'b01, 2'b00, 2'b01, 2'b00, 2'b10, 2'b01, 2'b10
    };

    // Result receiver: drops ready with a chance of about one in ten while gaps are on.
    always @(posedge i_clk)
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 10);

    // Every accepted result is checked against the oldest prediction.
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            angle_sb.check_angle_result(m_axis_tdata);

    // Valid stays high from one request to the next unless a gap is taken,
    // so it is never lowered and raised in the same time step.
    task automatic send_sample(input logic [1:0] phase);
        if (gaps_on) begin
            while ($urandom_range(99) < 10) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, phase[0], phase[1]};
        do @(posedge i_clk); while (!s_axis_tready);
        angle_sb.predict_sample(phase[1], phase[0]);
    endtask

    // Stop sending and let every owed result come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (angle_sb.expected_angles.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [CFG_BITS-1:0] ref_v, top_v, wide_v, narrow_v);
        qat_pkg::t_cfg_reg   order[4];
        logic [CFG_BITS-1:0] values[4];

        order  = '{qat_pkg::CFG_REF_ANGLE, qat_pkg::CFG_ANGLE_TOP,
                   qat_pkg::CFG_WIDE_BAND, qat_pkg::CFG_NARROW_BAND};
        values = '{ref_v, top_v, wide_v, narrow_v};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[i];
            i_cfg_data  <= values[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            angle_sb.write_register(order[i], values[i]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly clean rotation in one direction with random reversals, holds,
    // single back-steps and the odd double jump as noise.
    task automatic wander(input int n_samples);
        logic [1:0] p;
        bit         ccw;
        int         r;

        ccw = 1'($urandom_range(1));
        repeat (n_samples) begin
            p = angle_sb.last_phase;
            if ($urandom_range(99) < 4)
                ccw = !ccw;
            r = int'($urandom_range(99));
            if (r < 78)
                p = ccw ? ccw_next(p) : cw_next(p);
            else if (r >= 94)
                p = p ^ 2'b11;
            else if (r >= 88)
                p = ccw ? cw_next(p) : ccw_next(p);
            send_sample(p);
        end
    endtask

    // Random setting: mostly a small top so the angle wraps often, and half
    // the time a reference near the current angle so the band indicators toggle.
    task automatic random_setting();
        logic [CFG_BITS-1:0] ref_v, top_v, wide_v, narrow_v;

        top_v = CFG_BITS'(($urandom_range(3) == 0) ? $urandom_range(2047, 1)
                                                   : $urandom_range(40, 1));
        if ($urandom_range(1))
            ref_v = CFG_BITS'($urandom_range(2047));
        else
            ref_v = CFG_BITS'(int'(angle_sb.count) + int'($urandom_range(40)) - 20);
        wide_v   = CFG_BITS'(($urandom_range(3) == 0) ? $urandom_range(2047)
                                                      : $urandom_range(60));
        narrow_v = CFG_BITS'(($urandom_range(3) == 0) ? $urandom_range(2047)
                                                      : $urandom_range(30));
        set_registers(ref_v, top_v, wide_v, narrow_v);
    endtask

    initial begin
        angle_sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_walk[i])
            send_sample(opening_walk[i]);
        drain_results();

        // The count of about 900 sits far above this top: down steps
        // decrement it, the first up step wraps it to zero.
        set_registers(11'd0, 11'd2, 11'd0, 11'd0);
        wander(200);
        drain_results();

        // A zero top pins the angle at zero; widest bands and reference.
        set_registers(11'd2047, 11'd0, 11'd2047, 11'd2047);
        wander(150);
        drain_results();

        // Full range: going down from zero lands on 2047, the largest error.
        set_registers(11'd0, 11'd2047, 11'd2047, 11'd0);
        wander(200);
        drain_results();

        set_registers(11'd1, 11'd1, 11'd1, 11'd1);
        wander(150);
        drain_results();

        for (int run = 0; run < 6; run++) begin
            gaps_on = (run != 2);
            random_setting();
            wander(170);
            drain_results();
        end
        gaps_on = 1'b1;

        // Results trail their samples by two register stages; give any
        // stray result time to show up.
        repeat (8) @(posedge i_clk);
        $display("Checked %0d samples over %0d register settings.",
                 angle_sb.samples, settings_used);
        $display("The angle moved %0d times and wrapped %0d times.",
                 angle_sb.steps, angle_sb.wraps);
        if (angle_sb.mismatches == 0 && angle_sb.expected_angles.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
